// File: hw/rtl/micp_pkg.sv
// Shared types and constants for the masked image to column post encoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package micp_pkg;

    // Pixel code that marks a transparent pixel.
    localparam logic [15:0] TRANSPARENT = 16'hFF00;
    // Highest absolute start row; also the row step of a stopgap post.
    localparam int STOP_ROW = 254;
    // Longest run that one post can hold.
    localparam logic [7:0] MAX_RUN = 8'd255;
    // Byte that closes every column.
    localparam logic [7:0] COLUMN_END = 8'hFF;
    // Header size in bytes.
    localparam int HDR_BYTES = 8;
    // Width of the width and height register fields, and of the configuration data.
    localparam int SIZE_W = 11;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_LEFT   = 2'd2,
        CFG_TOP    = 2'd3
    } cfg_index_t;

    // Sequencer states; every state other than idle writes one byte per cycle while the output register is free.
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_HDR   = 11'b000_0000_0010,
        S_PTR   = 11'b000_0000_0100,
        S_TPAD  = 11'b000_0000_1000,
        S_SPAD  = 11'b000_0001_0000,
        S_EMPTY = 11'b000_0010_0000,
        S_START = 11'b000_0100_0000,
        S_PIX   = 11'b000_1000_0000,
        S_LEN   = 11'b001_0000_0000,
        S_EPAD  = 11'b010_0000_0000,
        S_EOC   = 11'b100_0000_0000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        state_t     state;
        logic [2:0] cnt;
        logic       accept;
        logic       emit;
        logic       last;
        logic       finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic in_opaque;
        logic opaque;
        logic in_post;
        logic len_full;
        logic hdr;
        logic ptr;
        logic col_end;
        logic first_now;
        logic rel_gt_now;
        logic first;
        logic rel_gt;
        logic rel_gt2;
    } status_t;

endpackage

// File: hw/rtl/micp_ctrl.sv
// Sequencer for the column post encoder: walks the byte writes of one pixel.
// Depends on micp_pkg for the state, command and status types.
module micp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  micp_pkg::status_t st,
    output micp_pkg::cmd_t    cmd
);

    micp_pkg::state_t state_reg, state_next;
    logic [2:0]       cnt_reg, cnt_next;
    micp_pkg::state_t after_state;
    logic [2:0]       last_cnt;

    // Pixel handling once header and pointer bytes are out of the way.
    function automatic micp_pkg::state_t pix_dispatch(
        input logic opaque, input logic in_post, input logic len_full,
        input logic first, input logic rel_gt, input logic col_end);
        micp_pkg::state_t nxt;
        if (!opaque) begin
            if (in_post) begin
                nxt = micp_pkg::S_TPAD;
            end else if (col_end) begin
                nxt = micp_pkg::S_EOC;
            end else begin
                nxt = micp_pkg::S_IDLE;
            end
        end else if (!in_post || len_full) begin
            if (in_post) begin
                nxt = micp_pkg::S_SPAD;
            end else if (first || rel_gt) begin
                nxt = micp_pkg::S_EMPTY;
            end else begin
                nxt = micp_pkg::S_START;
            end
        end else begin
            nxt = micp_pkg::S_PIX;
        end
        return nxt;
    endfunction

    // Successor of each writing state and the count of its final byte.
    always_comb begin
        after_state = micp_pkg::S_IDLE;
        last_cnt    = 3'd0;
        unique case (state_reg)
            micp_pkg::S_IDLE: begin
                after_state = micp_pkg::S_IDLE;
            end
            micp_pkg::S_HDR: begin
                after_state = micp_pkg::S_PTR;
                last_cnt    = 3'(micp_pkg::HDR_BYTES - 1);
            end
            micp_pkg::S_PTR: begin
                after_state = pix_dispatch(st.opaque, st.in_post, st.len_full,
                                           st.first, st.rel_gt, st.col_end);
                last_cnt    = 3'd3;
            end
            micp_pkg::S_TPAD: begin
                after_state = st.col_end ? micp_pkg::S_EOC : micp_pkg::S_IDLE;
            end
            micp_pkg::S_SPAD: begin
                after_state = (st.first || st.rel_gt) ? micp_pkg::S_EMPTY
                                                      : micp_pkg::S_START;
            end
            micp_pkg::S_EMPTY: begin
                // The first empty post does not step the relative row.
                if (st.first) begin
                    after_state = st.rel_gt ? micp_pkg::S_EMPTY : micp_pkg::S_START;
                end else begin
                    after_state = st.rel_gt2 ? micp_pkg::S_EMPTY : micp_pkg::S_START;
                end
                last_cnt = 3'd3;
            end
            micp_pkg::S_START: begin
                after_state = micp_pkg::S_PIX;
                last_cnt    = 3'd1;
            end
            micp_pkg::S_PIX: begin
                after_state = micp_pkg::S_LEN;
            end
            micp_pkg::S_LEN: begin
                after_state = st.col_end ? micp_pkg::S_EPAD : micp_pkg::S_IDLE;
            end
            micp_pkg::S_EPAD: begin
                after_state = micp_pkg::S_EOC;
            end
            micp_pkg::S_EOC: begin
                after_state = micp_pkg::S_IDLE;
            end
            default: begin
                after_state = micp_pkg::S_IDLE;
            end
        endcase
    end

    // Next state, byte counter and commands.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.state  = state_reg;
        cmd.cnt    = cnt_reg;
        if (state_reg == micp_pkg::S_IDLE) begin
            if (s_tvalid) begin
                cmd.accept = 1'b1;
                cnt_next   = 3'd0;
                if (st.hdr) begin
                    state_next = micp_pkg::S_HDR;
                end else if (st.ptr) begin
                    state_next = micp_pkg::S_PTR;
                end else begin
                    state_next = pix_dispatch(st.in_opaque, st.in_post, st.len_full,
                                              st.first_now, st.rel_gt_now, st.col_end);
                end
                cmd.finish = (state_next == micp_pkg::S_IDLE);
            end
        end else if (st.out_free) begin
            cmd.emit = 1'b1;
            if (cnt_reg == last_cnt) begin
                cnt_next   = 3'd0;
                state_next = after_state;
            end else begin
                cnt_next = cnt_reg + 3'd1;
            end
            cmd.last   = (state_next == micp_pkg::S_IDLE);
            cmd.finish = cmd.last;
        end
    end

    assign s_tready = (state_reg == micp_pkg::S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= micp_pkg::S_IDLE;
            cnt_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/micp_datapath.sv
// Datapath of the column post encoder: configuration, image state, byte
// address and value selection, and the output register. Depends on micp_pkg.
module micp_datapath #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int OUT_ADDR_BITS = 26
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [micp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [15:0]                   in_pixel,
    input  logic                          m_tready,
    output logic                          out_valid,
    output logic [OUT_ADDR_BITS-1:0]      out_offset,
    output logic [7:0]                    out_byte,
    output logic                          out_last,
    output logic                          out_done,
    input  micp_pkg::cmd_t                cmd,
    output micp_pkg::status_t             st
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = ($clog2(MAX_HEIGHT) > 8) ? $clog2(MAX_HEIGHT) : 8;
    localparam int AW     = OUT_ADDR_BITS;

    // Configuration registers.
    logic [micp_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [15:0]                 left_reg, top_reg;

    // Image and post state.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    psp_reg, psp_next;
    logic             in_post_reg, in_post_next;
    logic [7:0]       len_reg, len_next;
    logic [ROW_W-1:0] lsr_reg, lsr_next;

    // Per-pixel registers.
    logic [15:0]      pix_reg;
    logic             first_reg, first_next;
    logic [ROW_W-1:0] rel_reg, rel_next;

    // Output register.
    logic          out_valid_reg;
    logic [AW-1:0] out_offset_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg, out_done_reg;

    logic [15:0]      w_eff, h_eff;
    logic             col_end, img_end;
    logic             row_high;
    logic [ROW_W-1:0] rel_now, rel_base;
    logic             first_now;
    logic [AW-1:0]    ptr_base, hdr_wp;
    logic [15:0]      hdr_word;
    logic [31:0]      ptr_word;
    logic [AW-1:0]    byte_addr;
    logic [7:0]       byte_val;

    // A size of zero counts as one; a size above the maximum counts as the maximum.
    function automatic logic [15:0] clamp_size(input logic [micp_pkg::SIZE_W-1:0] v,
                                               input logic [15:0] maxv);
        logic [15:0] r;
        if (v == '0) begin
            r = 16'd1;
        end else if (16'(v) > maxv) begin
            r = maxv;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    assign w_eff = clamp_size(width_reg, 16'(MAX_WIDTH));
    assign h_eff = clamp_size(height_reg, 16'(MAX_HEIGHT));

    assign col_end = (16'(row_reg) + 16'd1) >= h_eff;
    assign img_end = (16'(col_reg) + 16'd1) >= w_eff;

    // Start row of a new post: absolute up to row 254, relative past it.
    assign row_high  = 16'(row_reg) > 16'(micp_pkg::STOP_ROW);
    assign first_now = row_high && (16'(lsr_reg) < 16'(micp_pkg::STOP_ROW));
    assign rel_base  = first_now ? ROW_W'(micp_pkg::STOP_ROW) : lsr_reg;
    assign rel_now   = row_high ? (row_reg - rel_base) : row_reg;

    // Status toward the controller.
    always_comb begin
        st            = '0;
        st.out_free   = !out_valid_reg || m_tready;
        st.in_opaque  = (in_pixel != micp_pkg::TRANSPARENT);
        st.opaque     = (pix_reg != micp_pkg::TRANSPARENT);
        st.in_post    = in_post_reg;
        st.len_full   = (len_reg == micp_pkg::MAX_RUN);
        st.hdr        = (col_reg == '0) && (row_reg == '0);
        st.ptr        = (row_reg == '0);
        st.col_end    = col_end;
        st.first_now  = first_now;
        st.rel_gt_now = 16'(rel_now) > 16'(micp_pkg::STOP_ROW);
        st.first      = first_reg;
        st.rel_gt     = 16'(rel_reg) > 16'(micp_pkg::STOP_ROW);
        st.rel_gt2    = 16'(rel_reg) > 16'(2 * micp_pkg::STOP_ROW);
    end

    // Header and column pointer sources.
    assign ptr_base = AW'(micp_pkg::HDR_BYTES) + AW'({col_reg, 2'b00});
    assign hdr_wp   = AW'(18'(micp_pkg::HDR_BYTES) + {w_eff, 2'b00});
    assign ptr_word = 32'(wp_reg);

    always_comb begin
        case (cmd.cnt[2:1])
            2'd0:    hdr_word = w_eff;
            2'd1:    hdr_word = h_eff;
            2'd2:    hdr_word = left_reg;
            default: hdr_word = top_reg;
        endcase
    end

    // Address and value of the byte written in the current state.
    always_comb begin
        byte_addr = wp_reg;
        byte_val  = 8'd0;
        unique case (cmd.state) inside
            micp_pkg::S_HDR: begin
                byte_addr = AW'(cmd.cnt);
                byte_val  = cmd.cnt[0] ? hdr_word[15:8] : hdr_word[7:0];
            end
            micp_pkg::S_PTR: begin
                byte_addr = ptr_base + AW'(cmd.cnt[1:0]);
                byte_val  = ptr_word[{cmd.cnt[1:0], 3'b000} +: 8];
            end
            micp_pkg::S_EMPTY: begin
                byte_val = (cmd.cnt == 3'd0) ? 8'(micp_pkg::STOP_ROW) : 8'd0;
            end
            micp_pkg::S_START: begin
                byte_addr = cmd.cnt[0] ? (wp_reg + AW'(2)) : wp_reg;
                byte_val  = cmd.cnt[0] ? 8'd0 : rel_reg[7:0];
            end
            micp_pkg::S_PIX: begin
                byte_val = pix_reg[7:0];
            end
            micp_pkg::S_LEN: begin
                byte_addr = psp_reg + AW'(1);
                byte_val  = len_reg;
            end
            micp_pkg::S_EOC: begin
                byte_val = micp_pkg::COLUMN_END;
            end
            micp_pkg::S_IDLE, micp_pkg::S_TPAD, micp_pkg::S_SPAD,
            micp_pkg::S_EPAD: begin
                byte_val = 8'd0;
            end
            default: begin
                byte_val = 8'd0;
            end
        endcase
    end

    // State updates for each written byte and at the end of a pixel.
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        wp_next      = wp_reg;
        psp_next     = psp_reg;
        in_post_next = in_post_reg;
        len_next     = len_reg;
        lsr_next     = lsr_reg;
        first_next   = first_reg;
        rel_next     = rel_reg;

        if (cmd.accept) begin
            first_next = first_now;
            rel_next   = rel_now;
        end

        if (cmd.emit) begin
            case (cmd.state) inside
                micp_pkg::S_HDR: begin
                    if (cmd.cnt == 3'(micp_pkg::HDR_BYTES - 1)) begin
                        wp_next = hdr_wp;
                    end
                end
                micp_pkg::S_TPAD: begin
                    wp_next      = wp_reg + AW'(1);
                    in_post_next = 1'b0;
                end
                micp_pkg::S_EMPTY: begin
                    wp_next = wp_reg + AW'(1);
                    if (cmd.cnt == 3'd3) begin
                        if (first_reg) begin
                            first_next = 1'b0;
                        end else begin
                            rel_next = rel_reg - ROW_W'(micp_pkg::STOP_ROW);
                        end
                    end
                end
                micp_pkg::S_START: begin
                    if (cmd.cnt[0]) begin
                        psp_next     = wp_reg;
                        wp_next      = wp_reg + AW'(3);
                        len_next     = 8'd0;
                        in_post_next = 1'b1;
                        lsr_next     = row_reg;
                    end
                end
                micp_pkg::S_PIX: begin
                    wp_next  = wp_reg + AW'(1);
                    len_next = len_reg + 8'd1;
                end
                micp_pkg::S_SPAD, micp_pkg::S_EPAD, micp_pkg::S_EOC: begin
                    wp_next = wp_reg + AW'(1);
                end
                default: begin
                    wp_next = wp_reg;
                end
            endcase
        end

        // Step to the next row, column or image.
        if (cmd.finish) begin
            if (col_end) begin
                in_post_next = 1'b0;
                len_next     = 8'd0;
                lsr_next     = '0;
                row_next     = '0;
                if (img_end) begin
                    col_next = '0;
                    wp_next  = '0;
                    psp_next = '0;
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= micp_pkg::SIZE_W'(1);
            height_reg <= micp_pkg::SIZE_W'(1);
            left_reg   <= 16'd0;
            top_reg    <= 16'd0;
        end else if (cfg_we) begin
            unique case (micp_pkg::cfg_index_t'(cfg_index))
                micp_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[micp_pkg::SIZE_W-1:0];
                micp_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[micp_pkg::SIZE_W-1:0];
                micp_pkg::CFG_LEFT:   left_reg   <= cfg_wdata;
                micp_pkg::CFG_TOP:    top_reg    <= cfg_wdata;
                default:              width_reg  <= width_reg;
            endcase
        end
    end

    // Image and post state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            wp_reg      <= '0;
            psp_reg     <= '0;
            in_post_reg <= 1'b0;
            len_reg     <= 8'd0;
            lsr_reg     <= '0;
            first_reg   <= 1'b0;
            rel_reg     <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            wp_reg      <= wp_next;
            psp_reg     <= psp_next;
            in_post_reg <= in_post_next;
            len_reg     <= len_next;
            lsr_reg     <= lsr_next;
            first_reg   <= first_next;
            rel_reg     <= rel_next;
        end
    end

    // Latched pixel of the transaction in progress.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= in_pixel;
        end
    end

    // Output register: loaded on each written byte, cleared when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_offset_reg <= byte_addr;
            out_byte_reg   <= byte_val;
            out_last_reg   <= cmd.last;
            out_done_reg   <= cmd.last && col_end && img_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_done   = out_done_reg;

endmodule

// File: hw/rtl/masked_image_to_column_posts.sv
// Top level of the masked image to column post encoder.
// Instantiates micp_ctrl and micp_datapath; depends on micp_pkg.
//
// Masked 16-bit pixels enter column by column, top row first, and come out as
// addressed byte writes that build a column-post image: an 8-byte header, one
// 32-bit pointer per column, then each column's posts closed by 0xFF. The
// sequencer hands one byte per cycle to the output register while it is free;
// back-pressure on the output holds the bytes back. An opaque pixel inside a
// post writes its palette byte and the post's length byte, a transparent pixel
// outside a post writes none unless it ends a column, the first pixel of an
// image also writes the header and its column pointer, and a pixel deep in a
// tall column that opens a post writes any stopgap posts it needs first. The
// output register lets the next pixel be accepted while the final byte of the
// previous one still waits to be taken. Configuration is to be written only
// while the block is idle; the block itself does not enforce this. No clearing
// pass follows reset.
module masked_image_to_column_posts #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int OUT_ADDR_BITS = 26
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [micp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Pixel input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] pixel
    // Byte write output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0 up: byte_offset, byte_value, zero fill to whole bytes.
    output logic [((OUT_ADDR_BITS + 15) / 8) * 8 - 1:0] m_tdata,
    output logic                            m_tlast,   // last write of the pixel
    output logic                            m_tuser    // [0] image_done
);

    localparam int DATA_W = ((OUT_ADDR_BITS + 15) / 8) * 8;

    micp_pkg::cmd_t    cmd;
    micp_pkg::status_t st;

    logic [OUT_ADDR_BITS-1:0] out_offset;
    logic [7:0]               out_byte;

    micp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    micp_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .OUT_ADDR_BITS (OUT_ADDR_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_pixel   (s_tdata),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_offset (out_offset),
        .out_byte   (out_byte),
        .out_last   (m_tlast),
        .out_done   (m_tuser),
        .cmd        (cmd),
        .st         (st)
    );

    // Pack offset and value, filled up with zeros.
    assign m_tdata = DATA_W'({out_byte, out_offset});

endmodule

// File: hw/rtl/micp_checker.sv
// Port-level checks for masked_image_to_column_posts, bound to the top level.
// Depends only on the top level's ports.
module micp_checker #(
    parameter int OUT_ADDR_BITS = 26
) (
    input logic                                        aclk,
    input logic                                        aresetn,
    input logic                                        s_tvalid,
    input logic                                        s_tready,
    input logic                                        m_tvalid,
    input logic                                        m_tready,
    input logic [((OUT_ADDR_BITS + 15) / 8) * 8 - 1:0] m_tdata,
    input logic                                        m_tlast,
    input logic                                        m_tuser
);

    // No write is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("write offered right after reset");

    // An idle input stays ready until a pixel transaction arrives.
    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !s_tvalid |=> s_tready)
        else $error("input ready dropped without a transaction");

    // A stalled write keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled write changed");

    // The end of an image is also the end of a pixel's writes.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image end without last write");

    // An image always ends on a column end byte.
    a_done_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OUT_ADDR_BITS +: 8] == 8'hFF)
        else $error("image end not on column end byte");

endmodule

bind masked_image_to_column_posts micp_checker #(
    .OUT_ADDR_BITS (OUT_ADDR_BITS)
) u_micp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: bench/micp_write_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the masked image to column post encoder: it watches the
// configuration port and both stream channels, predicts every byte write and
// compares. Depends on micp_pkg.
module micp_write_checker #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int OUT_ADDR_BITS = 26
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [micp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] pixel
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0 up: byte_offset, byte_value, zero fill.
    input  logic [((OUT_ADDR_BITS + 15) / 8) * 8 - 1:0] m_tdata,
    input  logic                            m_tlast,   // last write of the pixel
    input  logic                            m_tuser,   // [0] image_done
    output int                              mismatch_count,
    output int                              writes_pending
);
    import micp_pkg::*;

    localparam int ADDR_W     = OUT_ADDR_BITS;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
        logic              last;
        logic              done;
    } byte_write_t;

    // Shadow copy of the configuration registers.
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [15:0]       left_reg;
    logic [15:0]       top_reg;

    // Shadow copy of the encoder state.
    logic [9:0]        col;
    logic [9:0]        row;
    logic [ADDR_W-1:0] wptr;
    logic [ADDR_W-1:0] pstart;
    logic              open;
    logic [7:0]        plen;
    logic [9:0]        lastrow;

    // Writes caused by the pixel being encoded, then the ordered queue of
    // writes still to be seen on the output.
    byte_write_t burst [32];
    int          burst_n;
    byte_write_t pending_writes [$];

    byte_write_t seen;
    byte_write_t want;
    int          errors;

    function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    task automatic emit(input logic [ADDR_W-1:0] a, input logic [7:0] v);
        burst[burst_n] = '{addr: a, value: v, last: 1'b0, done: 1'b0};
        burst_n++;
    endtask

    task automatic emit_next(input logic [7:0] v);
        emit(wptr, v);
        wptr = wptr + 1'b1;
    endtask

    // An empty post: start row 254, length zero, two pad bytes.
    task automatic emit_empty_post();
        emit_next(8'(STOP_ROW));
        emit_next(8'd0);
        emit_next(8'd0);
        emit_next(8'd0);
    endtask

    // Works out every byte write one pixel causes and queues them in order.
    task automatic encode_pixel(input logic [15:0] pix);
        int          w;
        int          h;
        int          wy;
        logic [15:0] hdr [4];
        logic [31:0] ptr32;
        logic [ADDR_W-1:0] at;
        logic        finished;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        burst_n = 0;
        finished = 1'b0;

        // Header at the first pixel of an image.
        if (col == '0 && row == '0) begin
            hdr[0] = 16'(w);
            hdr[1] = 16'(h);
            hdr[2] = left_reg;
            hdr[3] = top_reg;
            for (int i = 0; i < 4; i++) begin
                emit(ADDR_W'(2 * i), hdr[i][7:0]);
                emit(ADDR_W'(2 * i + 1), hdr[i][15:8]);
            end
            wptr = ADDR_W'(HDR_BYTES + 4 * w);
        end

        // Column pointer at the top of each column.
        if (row == '0) begin
            at = ADDR_W'(HDR_BYTES + 4 * int'(col));
            ptr32 = 32'(wptr);
            for (int i = 0; i < 4; i++)
                emit(at + ADDR_W'(i), ptr32[8 * i +: 8]);
        end

        if (pix == TRANSPARENT) begin
            if (open)
                emit_next(8'd0);
            open = 1'b0;
        end else begin
            // A new post opens after a gap or once the current one is full.
            if (!open || plen >= MAX_RUN) begin
                wy = int'(row);
                if (open)
                    emit_next(8'd0);
                if (int'(row) > STOP_ROW) begin
                    if (int'(lastrow) < STOP_ROW) begin
                        emit_empty_post();
                        lastrow = 10'(STOP_ROW);
                    end
                    wy = int'(row) - int'(lastrow);
                    while (wy > STOP_ROW) begin
                        emit_empty_post();
                        wy -= STOP_ROW;
                    end
                end
                pstart = wptr;
                emit(wptr, 8'(wy));
                emit(wptr + ADDR_W'(2), 8'd0);
                wptr = wptr + ADDR_W'(3);
                plen = 8'd0;
                open = 1'b1;
                lastrow = row;
            end
            emit_next(pix[7:0]);
            plen = plen + 1'b1;
            emit(pstart + ADDR_W'(1), plen);
        end

        // Column end, and image end after the last column.
        if (int'(row) + 1 >= h) begin
            if (open)
                emit_next(8'd0);
            emit_next(COLUMN_END);
            open = 1'b0;
            plen = 8'd0;
            lastrow = '0;
            row = '0;
            if (int'(col) + 1 >= w) begin
                finished = 1'b1;
                col = '0;
                wptr = '0;
                pstart = '0;
            end else begin
                col = col + 1'b1;
            end
        end else begin
            row = row + 1'b1;
        end

        if (burst_n > 0) begin
            burst[burst_n - 1].last = 1'b1;
            burst[burst_n - 1].done = finished;
        end
        for (int i = 0; i < burst_n; i++)
            pending_writes.push_back(burst[i]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = SIZE_W'(1);
            height_reg = SIZE_W'(1);
            left_reg = '0;
            top_reg = '0;
            col = '0;
            row = '0;
            wptr = '0;
            pstart = '0;
            open = 1'b0;
            plen = '0;
            lastrow = '0;
            pending_writes.delete();
            errors = 0;
        end else begin
            // Register writes land at the edge where the enable is high.
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_WIDTH:  width_reg = cfg_wdata[SIZE_W-1:0];
                    CFG_HEIGHT: height_reg = cfg_wdata[SIZE_W-1:0];
                    CFG_LEFT:   left_reg = cfg_wdata[15:0];
                    CFG_TOP:    top_reg = cfg_wdata[15:0];
                    default: ;
                endcase
            end

            // Each accepted pixel transaction extends the expected writes.
            if (s_tvalid && s_tready)
                encode_pixel(s_tdata);

            // Each accepted write transaction is matched against the oldest one.
            if (m_tvalid && m_tready) begin
                seen.addr = m_tdata[ADDR_W-1:0];
                seen.value = m_tdata[ADDR_W +: 8];
                seen.last = m_tlast;
                seen.done = m_tuser;
                if (pending_writes.size() == 0) begin
                    errors++;
                    if (errors <= MAX_PRINTS)
                        $display("%0t: unexpected write, expected none, actual addr %h value %h last %b done %b",
                                 $time, seen.addr, seen.value, seen.last, seen.done);
                end else begin
                    want = pending_writes.pop_front();
                    if (want.addr !== seen.addr || want.value !== seen.value ||
                        want.last !== seen.last || want.done !== seen.done) begin
                        errors++;
                        if (errors <= MAX_PRINTS)
                            $display("%0t: write mismatch, expected addr %h value %h last %b done %b, actual addr %h value %h last %b done %b",
                                     $time, want.addr, want.value, want.last, want.done,
                                     seen.addr, seen.value, seen.last, seen.done);
                    end
                end
            end
        end
        mismatch_count <= errors;
        writes_pending <= pending_writes.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the encoder testbench: clock, reset, pixel stimulus, the output
// sink and the verdict. Depends on micp_pkg, micp_write_checker and the RTL.
module testbench;
    import micp_pkg::*;

    localparam int OUT_ADDR_BITS = 26;
    localparam int TDATA_W       = ((OUT_ADDR_BITS + 15) / 8) * 8;
    localparam int RANDOM_ITEMS  = 130;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;

    // Small image that walks through opaque runs, gaps and an empty column.
    localparam logic [15:0] DEMO_IMAGE [12] = '{
        16'h1234, TRANSPARENT, 16'hFF01, 16'h7F80,
        TRANSPARENT, TRANSPARENT, 16'hAB00, 16'h00CD,
        TRANSPARENT, TRANSPARENT, TRANSPARENT, TRANSPARENT
    };

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int mismatch_count;
    int writes_pending;
    int src_idle_pct = 16;
    int snk_idle_pct = 73;
    int hold_requests = 0;
    int random_items = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    masked_image_to_column_posts #(
        .OUT_ADDR_BITS(OUT_ADDR_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    micp_write_checker #(
        .OUT_ADDR_BITS(OUT_ADDR_BITS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .mismatch_count(mismatch_count),
        .writes_pending(writes_pending)
    );

    // Output sink: random back-pressure, plus a long hold-off on request.
    initial begin
        int served;
        int hold_left;
        served = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (served != hold_requests) begin
                served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("masked_image_to_column_posts verification failed");
        $finish;
    end

    // Offers one pixel transaction after a random gap and returns once accepted.
    task automatic send_pixel(input logic [15:0] p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Writes all four registers on consecutive edges.
    task automatic set_config(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] l, input logic [15:0] t);
        cfg_index_t  regs [4];
        logic [15:0] vals [4];
        regs = '{CFG_WIDTH, CFG_HEIGHT, CFG_LEFT, CFG_TOP};
        vals = '{w, h, l, t};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Stops offering pixels and waits until every expected write has come,
    // then lets a possible write-free pixel finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (writes_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          mode;
        int          w;
        int          h;
        int          count;
        int          run;
        bit          noisy;
        bit          opaque;
        logic [15:0] p;
        mode = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: every pixel is a whole one-by-one image.
        send_pixel(16'h0000);
        send_pixel(TRANSPARENT);

        // Zero sizes count as one; extreme offsets in the header.
        wait_idle();
        set_config(16'd0, 16'd0, 16'h8000, 16'h7FFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h00FF);

        // A full three-by-four image.
        wait_idle();
        set_config(16'd3, 16'd4, 16'hFFFF, 16'h0001);
        for (int i = 0; i < 12; i++)
            send_pixel(DEMO_IMAGE[i]);

        // Oversized width, then the width drops mid-image and ends it.
        wait_idle();
        set_config(16'h07FF, 16'd2, 16'h7FFF, 16'h8000);
        send_pixel(16'h8001);
        send_pixel(TRANSPARENT);
        send_pixel(16'h0180);
        send_pixel(16'hFE00);
        wait_idle();
        set_config(16'd1, 16'd2, 16'h0000, 16'h0000);
        send_pixel(16'h0001);
        send_pixel(TRANSPARENT);

        // A run longer than one post, which also crosses into relative rows.
        wait_idle();
        set_config(16'd1, 16'd257, pick_offset(), pick_offset());
        repeat (256) send_pixel(16'($urandom));
        send_pixel(TRANSPARENT);

        while (random_items < RANDOM_ITEMS) begin
            if (mode == 0 && random_items >= RANDOM_ITEMS / 3) begin
                // Swap the idle pattern.
                mode = 1;
                src_idle_pct <= 73;
                snk_idle_pct <= 16;
            end else if (mode == 1 && random_items >= 2 * RANDOM_ITEMS / 3) begin
                // No idling from here on; the sink holds off for a long
                // stretch while opaque pixels keep coming.
                mode = 2;
                src_idle_pct <= 0;
                snk_idle_pct <= 0;
                wait_idle();
                set_config(16'd5, 16'd8, pick_offset(), pick_offset());
                hold_requests <= hold_requests + 1;
                repeat (40) begin
                    send_pixel(16'($urandom));
                    random_items++;
                end
            end

            // A small image, sometimes left unfinished before the next setting.
            w = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            h = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            wait_idle();
            set_config(16'(w), 16'(h), pick_offset(), pick_offset());
            count = ($urandom_range(3) == 0) ? $urandom_range(1, w * h) : w * h;
            // Stay within the item budget.
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            noisy = ($urandom_range(9) == 0);
            opaque = $urandom_range(1);
            while (count > 0) begin
                run = opaque ? $urandom_range(1, 8) : $urandom_range(1, 4);
                while (run > 0 && count > 0) begin
                    if (noisy)
                        p = $urandom_range(1) ? TRANSPARENT : 16'($urandom);
                    else
                        p = opaque ? 16'($urandom) : TRANSPARENT;
                    send_pixel(p);
                    run--;
                    count--;
                    random_items++;
                end
                opaque = !opaque;
            end
        end

        wait_idle();
        if (mismatch_count == 0 && writes_pending == 0)
            $display("masked_image_to_column_posts verification clean");
        else
            $display("masked_image_to_column_posts verification failed");
        $finish;
    end

endmodule
